[sv/skhct_pkg.sv]
// Package: types, constants and commands for the string key hash counter table.
`default_nettype none
package skhct_pkg;
   localparam int TableDepth = 64;
   localparam int SlotBits = 6;
   localparam int SizeBits = 7;
   localparam int KeyBytes = 19;
   localparam int KeyBits = 152;
   localparam int LenBits = 5;
   localparam int HashBits = 32;
   localparam int ProbeBits = 8;
   localparam logic [HashBits-1:0] HashSeed = 32'd5381;

   localparam logic [2:0] REQ_PUT = 3'd0;
   localparam logic [2:0] REQ_GET = 3'd1;
   localparam logic [2:0] REQ_INC = 3'd2;
   localparam logic [2:0] REQ_SUM = 3'd3;
   localparam logic [2:0] REQ_MAX = 3'd4;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE, S_HASH, S_MOD, S_PROBE_RD, S_PROBE_CK, S_SCAN_RD, S_SCAN_CK,
      S_MAX_RD, S_FINISH, S_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic hash_step;
      logic mod_step;
      logic probe_init;
      logic probe_rd;
      logic probe_next;
      logic set_free_mode;
      logic scan_init;
      logic scan_rd;
      logic scan_acc;
      logic max_rd;
      logic do_write;
      logic write_inc;
      logic finish;
      logic clear_init;
   } cmd_type;

   typedef struct packed {
      logic [2:0] req;
      logic hash_done;
      logic mod_done;
      logic hit;
      logic free_hit;
      logic free_mode;
      logic probes_done;
      logic scan_done;
   } stat_type;
endpackage
`default_nettype wire

[sv/skhct_datapath.sv]
// Datapath: key capture, hash, modulo, slot memory, probe and scan logic.
`default_nettype none
module skhct_datapath (
   input  wire logic clock,
   input  wire logic reset,
   input  wire skhct_pkg::cmd_type cmd,
   output skhct_pkg::stat_type stat,
   input  wire logic [skhct_pkg::SizeBits-1:0] size_raw,
   input  wire logic [2:0] req_type,
   input  wire logic [4:0] key_len,
   input  wire logic [63:0] key_word0,
   input  wire logic [63:0] key_word1,
   input  wire logic [23:0] key_word2,
   input  wire logic signed [31:0] new_value,
   output logic [1:0] status,
   output logic signed [31:0] result_value,
   output logic [4:0] max_key_len,
   output logic [63:0] max_key_word0,
   output logic [63:0] max_key_word1,
   output logic [23:0] max_key_word2
);
   localparam int SB = skhct_pkg::SlotBits;
   localparam int ZB = skhct_pkg::SizeBits;
   localparam int KB = skhct_pkg::KeyBits;
   localparam int LB = skhct_pkg::LenBits;
   localparam int HB = skhct_pkg::HashBits;
   localparam int PB = skhct_pkg::ProbeBits;

   logic [ZB-1:0] size_eff;
   always_comb begin
      if (size_raw == '0) size_eff = ZB'(1);
      else if (size_raw > ZB'(skhct_pkg::TableDepth)) size_eff = ZB'(skhct_pkg::TableDepth);
      else size_eff = size_raw;
   end

   logic [2:0] req_ff;
   logic [LB-1:0] len_ff, len_in;
   logic [KB-1:0] raw_ff, key_ff;
   logic [31:0] newv_ff;
   logic [LB-1:0] idx_ff;
   logic hash_end_ff;
   logic [HB-1:0] hash_ff;
   logic [HB-1:0] rem_ff;
   logic [5:0] mbit_ff;
   logic [SB-1:0] home_ff, slot_ff;
   logic [PB-1:0] j_ff;
   logic [ZB-1:0] k_ff;
   logic first_ff, free_mode_ff;
   logic [SB-1:0] scan_ff;
   logic [31:0] acc_ff;
   logic signed [32:0] best_ff;
   logic [SB-1:0] at_ff;
   logic [1:0] st_ff;
   logic [31:0] val_ff;
   logic [LB-1:0] olen_ff;
   logic [KB-1:0] okey_ff;
   logic [skhct_pkg::TableDepth-1:0] valid_ff;
   // value written by the last store, held for the response
   logic [31:0] wr_cnt_hold;

   logic [LB-1:0] len_sat;
   always_comb begin
      len_sat = (key_len > LB'(skhct_pkg::KeyBytes)) ? LB'(skhct_pkg::KeyBytes) : key_len;
      len_in = len_sat;
   end

   // memories
   logic [LB-1:0] mem_len [skhct_pkg::TableDepth];
   logic [KB-1:0] mem_key [skhct_pkg::TableDepth];
   logic [31:0] mem_cnt [skhct_pkg::TableDepth];
   logic [LB-1:0] rd_len;
   logic [KB-1:0] rd_key;
   logic [31:0] rd_cnt;
   logic rd_valid;
   logic [SB-1:0] rd_addr;
   logic [SB-1:0] wr_addr;
   logic [31:0] wr_cnt;

   always_comb begin
      if (cmd.scan_rd) rd_addr = scan_ff;
      else if (cmd.max_rd) rd_addr = at_ff;
      else rd_addr = slot_ff;
   end

   always_ff @(posedge clock) begin
      rd_len <= mem_len[rd_addr];
      rd_key <= mem_key[rd_addr];
      rd_cnt <= mem_cnt[rd_addr];
      rd_valid <= valid_ff[rd_addr];
   end

   assign wr_addr = slot_ff;
   assign wr_cnt = cmd.write_inc ? (stat.hit ? rd_cnt + 32'd1 : 32'd1) : newv_ff;

   always_ff @(posedge clock) begin
      if (cmd.do_write) begin
         mem_cnt[wr_addr] <= wr_cnt;
         if (!stat.hit) begin
            mem_len[wr_addr] <= len_ff;
            mem_key[wr_addr] <= key_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_init) valid_ff <= '0;
      else if (cmd.do_write) valid_ff[wr_addr] <= 1'b1;
   end

   // hashing, one byte per cycle
   logic [7:0] cur_byte;
   assign cur_byte = raw_ff[idx_ff*8 +: 8];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_type;
         len_ff <= len_in;
         raw_ff <= {key_word2[23:0], key_word1, key_word0};
         key_ff <= '0;
         newv_ff <= new_value;
         idx_ff <= '0;
         hash_ff <= skhct_pkg::HashSeed;
         hash_end_ff <= (len_in == '0);
      end else if (cmd.hash_step) begin
         if (cur_byte == 8'd0) begin
            len_ff <= idx_ff;
            hash_end_ff <= 1'b1;
         end else begin
            key_ff[idx_ff*8 +: 8] <= cur_byte;
            hash_ff <= (hash_ff << 5) + hash_ff + HB'(cur_byte);
            idx_ff <= idx_ff + LB'(1);
            hash_end_ff <= (idx_ff + LB'(1) == len_ff);
         end
      end
   end

   // restoring remainder, one bit per cycle; mbit counts from 32, the bit index is mbit-1
   logic [HB:0] rem_sh;
   assign rem_sh = {rem_ff, hash_ff[5'(mbit_ff - 6'd1)]};
   always_ff @(posedge clock) begin
      if (cmd.hash_step || cmd.load) begin
         rem_ff <= '0;
         mbit_ff <= 6'(HB);
      end else if (cmd.mod_step) begin
         if (rem_sh >= (HB+1)'(size_eff)) rem_ff <= HB'(rem_sh - (HB+1)'(size_eff));
         else rem_ff <= HB'(rem_sh);
         mbit_ff <= mbit_ff - 6'd1;
      end
   end

   // probe sequencing
   logic [ZB:0] sum_a;
   logic [ZB+1:0] sum_b;
   logic [ZB-1:0] k2;
   logic [SB-1:0] next_slot;
   always_comb begin
      sum_a = (ZB+1)'(home_ff) + (ZB+1)'(j_ff[SB:0]);
      if (sum_a >= (ZB+1)'(size_eff)) sum_a = sum_a - (ZB+1)'(size_eff);
      if (sum_a >= (ZB+1)'(size_eff)) sum_a = sum_a - (ZB+1)'(size_eff);
      sum_b = (ZB+2)'(sum_a) + (ZB+2)'(k_ff);
      if (sum_b >= (ZB+2)'(size_eff)) sum_b = sum_b - (ZB+2)'(size_eff);
      next_slot = sum_b[SB-1:0];
      k2 = {k_ff[ZB-2:0], 1'b0};
      if (k2 >= size_eff) k2 = k2 - size_eff;
   end

   logic [SB-1:0] home_val;
   assign home_val = rem_ff[SB-1:0];

   always_ff @(posedge clock) begin
      if (cmd.set_free_mode) free_mode_ff <= 1'b1;
      else if (cmd.load) free_mode_ff <= (req_type == skhct_pkg::REQ_PUT);
      if (cmd.probe_init) begin
         home_ff <= home_val;
         slot_ff <= home_val;
         j_ff <= '0;
         k_ff <= (size_eff == ZB'(1)) ? '0 : ZB'(1);
         first_ff <= 1'b1;
      end else if (cmd.probe_next) begin
         first_ff <= 1'b0;
         j_ff <= j_ff + PB'(1);
         k_ff <= k2;
         slot_ff <= next_slot;
      end
   end

   logic match, freeslot;
   assign match = rd_valid && rd_len == len_ff && rd_key == key_ff;
   assign freeslot = free_mode_ff && !rd_valid;

   // scans
   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         scan_ff <= '0;
         acc_ff <= '0;
         best_ff <= -33'sd1;
         at_ff <= '0;
      end else if (cmd.scan_acc) begin
         if (rd_valid) begin
            acc_ff <= acc_ff + rd_cnt;
            if ($signed({rd_cnt[31], rd_cnt}) > best_ff) begin
               best_ff <= $signed({rd_cnt[31], rd_cnt});
               at_ff <= scan_ff;
            end
         end
         scan_ff <= scan_ff + SB'(1);
      end
   end

   // result
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         st_ff <= skhct_pkg::ST_OK;
         val_ff <= '0;
         olen_ff <= '0;
         okey_ff <= '0;
         case (req_ff)
            skhct_pkg::REQ_PUT, skhct_pkg::REQ_INC: begin
               if (!stat.hit && !stat.free_hit) begin
                  st_ff <= skhct_pkg::ST_FULL;
                  val_ff <= '1;
               end else val_ff <= wr_cnt_hold;
            end
            skhct_pkg::REQ_GET: begin
               if (!stat.hit) begin
                  st_ff <= skhct_pkg::ST_MISS;
                  val_ff <= '1;
               end else val_ff <= rd_cnt;
            end
            skhct_pkg::REQ_SUM: val_ff <= acc_ff;
            skhct_pkg::REQ_MAX: begin
               if (best_ff < 0) begin
                  st_ff <= skhct_pkg::ST_MISS;
                  val_ff <= '1;
               end else begin
                  val_ff <= rd_cnt;
                  olen_ff <= rd_len;
                  okey_ff <= rd_key;
               end
            end
            default: begin
               st_ff <= skhct_pkg::ST_MISS;
               val_ff <= '1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_write) wr_cnt_hold <= wr_cnt;
   end

   always_comb begin
      stat.req = req_ff;
      stat.hash_done = hash_end_ff;
      stat.mod_done = (mbit_ff == 6'd0);
      stat.hit = match;
      stat.free_hit = freeslot;
      stat.free_mode = free_mode_ff;
      stat.probes_done = !first_ff && (j_ff == PB'({size_eff, 1'b0}));
      stat.scan_done = (ZB'(scan_ff) + ZB'(1) >= size_eff);
   end

   assign status = st_ff;
   assign result_value = val_ff;
   assign max_key_len = olen_ff;
   assign max_key_word0 = okey_ff[63:0];
   assign max_key_word1 = okey_ff[127:64];
   assign max_key_word2 = okey_ff[151:128];
endmodule
`default_nettype wire

[sv/skhct_ctrl.sv]
// Controller: sequences hashing, probing, scanning and the response handshake.
`default_nettype none
module skhct_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   input  wire logic csr_we,
   output skhct_pkg::cmd_type cmd,
   input  wire skhct_pkg::stat_type stat
);
   skhct_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= skhct_pkg::S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         skhct_pkg::S_IDLE:
            if (csr_we) state_in = skhct_pkg::S_IDLE;
            else if (req_valid) state_in = skhct_pkg::S_HASH;
         skhct_pkg::S_HASH:
            if (stat.hash_done) state_in = skhct_pkg::S_MOD;
         skhct_pkg::S_MOD:
            if (stat.mod_done) begin
               if (stat.req == skhct_pkg::REQ_SUM || stat.req == skhct_pkg::REQ_MAX)
                  state_in = skhct_pkg::S_SCAN_RD;
               else if (stat.req == skhct_pkg::REQ_PUT || stat.req == skhct_pkg::REQ_GET
                        || stat.req == skhct_pkg::REQ_INC)
                  state_in = skhct_pkg::S_PROBE_RD;
               else state_in = skhct_pkg::S_FINISH;
            end
         skhct_pkg::S_PROBE_RD: state_in = skhct_pkg::S_PROBE_CK;
         skhct_pkg::S_PROBE_CK:
            if (stat.hit || stat.free_hit) state_in = skhct_pkg::S_FINISH;
            else if (stat.probes_done) begin
               if (stat.req == skhct_pkg::REQ_INC && !stat.free_mode)
                  state_in = skhct_pkg::S_PROBE_RD;
               else state_in = skhct_pkg::S_FINISH;
            end else state_in = skhct_pkg::S_PROBE_RD;
         skhct_pkg::S_SCAN_RD: state_in = skhct_pkg::S_SCAN_CK;
         skhct_pkg::S_SCAN_CK:
            if (stat.scan_done) state_in = skhct_pkg::S_MAX_RD;
            else state_in = skhct_pkg::S_SCAN_RD;
         skhct_pkg::S_MAX_RD: state_in = skhct_pkg::S_FINISH;
         skhct_pkg::S_FINISH: state_in = skhct_pkg::S_OUT;
         skhct_pkg::S_OUT:
            if (rsp_ready) state_in = skhct_pkg::S_IDLE;
         default: state_in = skhct_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         skhct_pkg::S_IDLE: begin
            req_ready = !csr_we;
            cmd.load = req_valid && !csr_we;
            cmd.clear_init = csr_we;
         end
         skhct_pkg::S_HASH: cmd.hash_step = !stat.hash_done;
         skhct_pkg::S_MOD: begin
            cmd.mod_step = !stat.mod_done;
            cmd.probe_init = stat.mod_done;
            cmd.scan_init = stat.mod_done;
         end
         skhct_pkg::S_PROBE_RD: cmd.probe_rd = 1'b1;
         skhct_pkg::S_PROBE_CK: begin
            cmd.do_write = (stat.hit || stat.free_hit) &&
                           (stat.req == skhct_pkg::REQ_PUT || stat.req == skhct_pkg::REQ_INC);
            cmd.write_inc = stat.req == skhct_pkg::REQ_INC;
            cmd.probe_next = !(stat.hit || stat.free_hit) && !stat.probes_done;
            cmd.set_free_mode = !(stat.hit || stat.free_hit) && stat.probes_done;
            cmd.probe_init = cmd.set_free_mode;
         end
         skhct_pkg::S_SCAN_RD: cmd.scan_rd = 1'b1;
         skhct_pkg::S_SCAN_CK: cmd.scan_acc = 1'b1;
         skhct_pkg::S_MAX_RD: cmd.max_rd = 1'b1;
         skhct_pkg::S_FINISH: cmd.finish = 1'b1;
         skhct_pkg::S_OUT: rsp_valid = 1'b1;
         default: cmd = '0;
      endcase
   end

`ifndef ASSERT_OFF
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("accept during response");
   a_write_probe: assert property (@(posedge clock) disable iff (reset)
      cmd.do_write |-> state_ff == skhct_pkg::S_PROBE_CK) else $error("stray write");
`endif
endmodule
`default_nettype wire

[sv/string_key_hash_counter_table_top.sv]
// Top level of the string key hash counter table.
// Requests arrive on req_* (valid/ready); one response word leaves on rsp_* per request.
// The block serves one request at a time: it hashes the key one byte per cycle,
// reduces the hash modulo the table size one bit per cycle, and reads each
// slot visited through a registered memory read before checking it. A key
// takes one hash step per byte, plus one when a zero byte ends the key. The
// slots probed are 1 for a hit at home, up to 2*size+1 per pass, and two passes
// when an increment inserts a new key. Sum and max scan every slot.
// The next request is accepted in the cycle after the response word is taken.
// csr_we writes table_size and, while idle, clears all entries together (valid bits are
// flip-flops); the user must write it only while idle, the block does not enforce this.
// Reset clears the entries and sets the size to 64. While rsp_ready is low the
// response holds and no new request is taken.
`default_nettype none
module string_key_hash_counter_table_top (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [2:0] req_type,
   input  wire logic [4:0] req_key_len,
   input  wire logic [63:0] req_key_word0,
   input  wire logic [63:0] req_key_word1,
   input  wire logic [23:0] req_key_word2,
   input  wire logic signed [31:0] req_new_value,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [1:0] rsp_status,
   output logic signed [31:0] rsp_result_value,
   output logic [4:0] rsp_max_key_len,
   output logic [63:0] rsp_max_key_word0,
   output logic [63:0] rsp_max_key_word1,
   output logic [23:0] rsp_max_key_word2,
   input  wire logic csr_we,
   input  wire logic [6:0] csr_wdata
);
   skhct_pkg::cmd_type cmd;
   skhct_pkg::stat_type stat;
   logic [skhct_pkg::SizeBits-1:0] size_ff;

   always_ff @(posedge clock) begin
      if (reset) size_ff <= skhct_pkg::SizeBits'(skhct_pkg::TableDepth);
      else if (csr_we) size_ff <= csr_wdata;
   end

   skhct_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .csr_we,
      .cmd, .stat
   );

   skhct_datapath u_dp (
      .clock, .reset, .cmd, .stat, .size_raw(size_ff),
      .req_type, .key_len(req_key_len), .key_word0(req_key_word0),
      .key_word1(req_key_word1), .key_word2(req_key_word2), .new_value(req_new_value),
      .status(rsp_status), .result_value(rsp_result_value),
      .max_key_len(rsp_max_key_len), .max_key_word0(rsp_max_key_word0),
      .max_key_word1(rsp_max_key_word1), .max_key_word2(rsp_max_key_word2)
   );
endmodule
`default_nettype wire

[tb/tb_string_key_hash_counter_table_top.sv]
// Testbench for the string key hash counter table: directed table and size checks, then random traffic.
`default_nettype none
module tb_string_key_hash_counter_table_top;
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_type = skhct_pkg::REQ_PUT;
   logic [4:0] req_key_len = '0;
   logic [63:0] req_key_word0 = '0;
   logic [63:0] req_key_word1 = '0;
   logic [23:0] req_key_word2 = '0;
   logic signed [31:0] req_new_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic signed [31:0] rsp_result_value;
   logic [4:0] rsp_max_key_len;
   logic [63:0] rsp_max_key_word0;
   logic [63:0] rsp_max_key_word1;
   logic [23:0] rsp_max_key_word2;
   logic csr_we = 1'b0;
   logic [6:0] csr_wdata = '0;

   string_key_hash_counter_table_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_key_len(req_key_len), .req_key_word0(req_key_word0),
      .req_key_word1(req_key_word1), .req_key_word2(req_key_word2),
      .req_new_value(req_new_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_result_value(rsp_result_value), .rsp_max_key_len(rsp_max_key_len),
      .rsp_max_key_word0(rsp_max_key_word0), .rsp_max_key_word1(rsp_max_key_word1),
      .rsp_max_key_word2(rsp_max_key_word2),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   typedef struct packed {
      logic [2:0] op;
      logic [4:0] len;
      logic [63:0] w0;
      logic [63:0] w1;
      logic [23:0] w2;
      logic [31:0] value;
   } request_type;

   typedef struct packed {
      logic [1:0] status;
      logic [31:0] value;
      logic [4:0] len;
      logic [63:0] w0;
      logic [63:0] w1;
      logic [23:0] w2;
   } answer_type;

   typedef struct packed {
      request_type req;
      logic fixed;
      answer_type ans;
   } row_type;

   // shadow table
   logic shadow_valid [skhct_pkg::TableDepth];
   logic [4:0] shadow_len [skhct_pkg::TableDepth];
   logic [skhct_pkg::KeyBits-1:0] shadow_key [skhct_pkg::TableDepth];
   logic [31:0] shadow_count [skhct_pkg::TableDepth];
   logic [6:0] size_reg;

   answer_type pending_answers[$];
   int mismatches = 0;
   int answered = 0;

   // key pool for random traffic
   request_type key_pool [16];

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #40000000;
      $display("tb: failure");
      $finish;
   end

   function automatic int active_size();
      if (size_reg == 0) return 1;
      if (size_reg > skhct_pkg::TableDepth) return skhct_pkg::TableDepth;
      return size_reg;
   endfunction

   function automatic void clear_shadow(logic [6:0] size);
      size_reg = size;
      for (int i = 0; i < skhct_pkg::TableDepth; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_len[i] = '0;
         shadow_key[i] = '0;
         shadow_count[i] = '0;
      end
   endfunction

   function automatic int find_slot(logic [skhct_pkg::KeyBits-1:0] key, logic [4:0] len,
                                    int home, bit take_free);
      int size;
      int k;
      int s;
      size = active_size();
      k = 1 % size;
      s = home;
      for (int j = -1; j < 2 * size; j++) begin
         if (j >= 0) begin
            s = (home + j + k) % size;
            k = (k * 2) % size;
         end
         if ((take_free && !shadow_valid[s]) ||
             (shadow_valid[s] && shadow_len[s] == len && shadow_key[s] == key))
            return s;
      end
      return -1;
   endfunction

   function automatic void put_slot(int s, logic [skhct_pkg::KeyBits-1:0] key,
                                    logic [4:0] len, logic [31:0] v);
      shadow_valid[s] = 1'b1;
      shadow_len[s] = len;
      shadow_key[s] = key;
      shadow_count[s] = v;
   endfunction

   function automatic answer_type table_answer(request_type r);
      answer_type a;
      logic [skhct_pkg::KeyBits-1:0] raw;
      logic [skhct_pkg::KeyBits-1:0] key;
      logic [4:0] len;
      logic [7:0] b;
      logic [31:0] h;
      logic [31:0] total;
      int home;
      int s;
      longint best;
      int at;
      a = '0;
      raw = {r.w2, r.w1, r.w0};
      key = '0;
      len = (r.len > skhct_pkg::KeyBytes) ? 5'(skhct_pkg::KeyBytes) : r.len;
      h = skhct_pkg::HashSeed;
      for (int i = 0; i < skhct_pkg::KeyBytes; i++) begin
         if (i < len) begin
            b = raw[8*i +: 8];
            if (b == 0) begin
               len = 5'(i);
               break;
            end
            key[8*i +: 8] = b;
            h = h * 33 + b;
         end
      end
      home = int'(h % active_size());
      case (r.op)
         skhct_pkg::REQ_PUT: begin
            s = find_slot(key, len, home, 1);
            if (s < 0) begin
               a.status = skhct_pkg::ST_FULL;
               a.value = '1;
            end else begin
               put_slot(s, key, len, r.value);
               a.value = r.value;
            end
         end
         skhct_pkg::REQ_GET: begin
            s = find_slot(key, len, home, 0);
            if (s < 0) begin
               a.status = skhct_pkg::ST_MISS;
               a.value = '1;
            end else a.value = shadow_count[s];
         end
         skhct_pkg::REQ_INC: begin
            s = find_slot(key, len, home, 0);
            if (s >= 0) begin
               shadow_count[s] = shadow_count[s] + 1;
               a.value = shadow_count[s];
            end else begin
               s = find_slot(key, len, home, 1);
               if (s < 0) begin
                  a.status = skhct_pkg::ST_FULL;
                  a.value = '1;
               end else begin
                  put_slot(s, key, len, 32'd1);
                  a.value = 32'd1;
               end
            end
         end
         skhct_pkg::REQ_SUM: begin
            total = '0;
            for (int i = 0; i < active_size(); i++)
               if (shadow_valid[i]) total += shadow_count[i];
            a.value = total;
         end
         skhct_pkg::REQ_MAX: begin
            best = -1;
            at = -1;
            for (int i = 0; i < active_size(); i++)
               if (shadow_valid[i] && longint'($signed(shadow_count[i])) > best) begin
                  best = longint'($signed(shadow_count[i]));
                  at = i;
               end
            if (at < 0) begin
               a.status = skhct_pkg::ST_MISS;
               a.value = '1;
            end else begin
               a.value = shadow_count[at];
               a.len = shadow_len[at];
               {a.w2, a.w1, a.w0} = shadow_key[at];
            end
         end
         default: begin
            a.status = skhct_pkg::ST_MISS;
            a.value = '1;
         end
      endcase
      return a;
   endfunction

   task automatic idle_cycles(int n);
      repeat (n) @(negedge clock);
   endtask

   function automatic int gap_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // valid stays high after a word is taken when the next word follows with no gap
   task automatic send_word(request_type r, bit fixed, answer_type expected);
      answer_type a;
      int n;
      n = gap_length();
      if (n > 0) begin
         req_valid <= 1'b0;
         idle_cycles(n);
      end
      a = table_answer(r);
      if (fixed && a != expected) begin
         mismatches++;
         if (mismatches <= 10)
            $display("table row disagrees with predictor: row %h pred %h", expected, a);
      end
      pending_answers.push_back(a);
      req_type <= r.op;
      req_key_len <= r.len;
      req_key_word0 <= r.w0;
      req_key_word1 <= r.w1;
      req_key_word2 <= r.w2;
      req_new_value <= r.value;
      req_valid <= 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
      idle_cycles(400);
   endtask

   task automatic write_size(logic [6:0] size);
      drain();
      csr_wdata <= size;
      csr_we <= 1'b1;
      @(negedge clock);
      csr_we <= 1'b0;
      clear_shadow(size);
   endtask

   function automatic request_type make_key(logic [2:0] op, int max_len);
      request_type r;
      r.op = op;
      r.len = 5'($urandom_range(0, max_len));
      r.w0 = {$urandom, $urandom};
      r.w1 = {$urandom, $urandom};
      r.w2 = 24'($urandom);
      r.value = $urandom;
      return r;
   endfunction

   // response side: random stalls, compare against oldest expectation
   initial begin
      answer_type want;
      answer_type got;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 99) < 8) begin
            rsp_ready <= 1'b0;
            idle_cycles($urandom_range(0, 99) < 85 ? $urandom_range(1, 4)
                                                   : $urandom_range(20, 80));
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got = {rsp_status, rsp_result_value, rsp_max_key_len,
                   rsp_max_key_word0, rsp_max_key_word1, rsp_max_key_word2};
            if (pending_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected word %h", got);
            end else begin
               want = pending_answers.pop_front();
               if (got != want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("word %0d: exp st=%0d val=%0d len=%0d key=%h_%h_%h ",
                              answered, want.status, $signed(want.value), want.len,
                              want.w2, want.w1, want.w0,
                              "act st=%0d val=%0d len=%0d key=%h_%h_%h", got.status,
                              $signed(got.value), got.len, got.w2, got.w1, got.w0);
               end
            end
            answered++;
         end
      end
   end

   initial begin
      row_type rows [$];
      request_type r;
      int n;
      clear_shadow(7'd64);
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: op, len, w0, w1, w2, value | fixed | status, value, len, key
      rows = '{
         '{'{skhct_pkg::REQ_SUM, 5'd0, 64'h0, 64'h0, 24'h0, 32'h0}, 1'b1,
           '{skhct_pkg::ST_OK, 32'h0, 5'd0, 64'h0, 64'h0, 24'h0}},
         '{'{skhct_pkg::REQ_MAX, 5'd0, 64'h0, 64'h0, 24'h0, 32'h0}, 1'b1,
           '{skhct_pkg::ST_MISS, 32'hffffffff, 5'd0, 64'h0, 64'h0, 24'h0}},
         '{'{skhct_pkg::REQ_GET, 5'd3, 64'h636261, 64'h0, 24'h0, 32'h0}, 1'b1,
           '{skhct_pkg::ST_MISS, 32'hffffffff, 5'd0, 64'h0, 64'h0, 24'h0}},
         '{'{skhct_pkg::REQ_PUT, 5'd3, 64'h636261, 64'h0, 24'h0, 32'h7fffffff}, 1'b1,
           '{skhct_pkg::ST_OK, 32'h7fffffff, 5'd0, 64'h0, 64'h0, 24'h0}},
         '{'{skhct_pkg::REQ_INC, 5'd3, 64'h636261, 64'h0, 24'h0, 32'h0}, 1'b1,
           '{skhct_pkg::ST_OK, 32'h80000000, 5'd0, 64'h0, 64'h0, 24'h0}},
         '{'{skhct_pkg::REQ_PUT, 5'd0, 64'h0, 64'h0, 24'h0, 32'h80000000}, 1'b1,
           '{skhct_pkg::ST_OK, 32'h80000000, 5'd0, 64'h0, 64'h0, 24'h0}},
         '{'{skhct_pkg::REQ_INC, 5'd2, 64'hff, 64'h0, 24'h0, 32'h0}, 1'b1,
           '{skhct_pkg::ST_OK, 32'h1, 5'd0, 64'h0, 64'h0, 24'h0}},
         '{'{skhct_pkg::REQ_PUT, 5'd31, 64'hffffffffffffffff, 64'hffffffffffffffff,
             24'hffffff, 32'hffffffff}, 1'b1,
           '{skhct_pkg::ST_OK, 32'hffffffff, 5'd0, 64'h0, 64'h0, 24'h0}},
         '{'{skhct_pkg::REQ_GET, 5'd19, 64'hffffffffffffffff, 64'hffffffffffffffff,
             24'hffffff, 32'h0}, 1'b1,
           '{skhct_pkg::ST_OK, 32'hffffffff, 5'd0, 64'h0, 64'h0, 24'h0}},
         '{'{skhct_pkg::REQ_GET, 5'd5, 64'h00ff, 64'h0, 24'h0, 32'h0}, 1'b0, '0},
         '{'{skhct_pkg::REQ_SUM, 5'd0, 64'h0, 64'h0, 24'h0, 32'h0}, 1'b0, '0},
         '{'{skhct_pkg::REQ_MAX, 5'd0, 64'h0, 64'h0, 24'h0, 32'h0}, 1'b1,
           '{skhct_pkg::ST_OK, 32'h1, 5'd1, 64'hff, 64'h0, 24'h0}},
         '{'{3'd5, 5'd3, 64'h636261, 64'h0, 24'h0, 32'h0}, 1'b1,
           '{skhct_pkg::ST_MISS, 32'hffffffff, 5'd0, 64'h0, 64'h0, 24'h0}},
         '{'{3'd7, 5'd0, 64'h0, 64'h0, 24'h0, 32'h0}, 1'b1,
           '{skhct_pkg::ST_MISS, 32'hffffffff, 5'd0, 64'h0, 64'h0, 24'h0}}
      };
      foreach (rows[i]) send_word(rows[i].req, rows[i].fixed, rows[i].ans);

      // size 1: second key is full, size 0 acts as 1
      write_size(7'd1);
      send_word('{skhct_pkg::REQ_PUT, 5'd1, 64'h41, 64'h0, 24'h0, 32'd5}, 1'b1,
                '{skhct_pkg::ST_OK, 32'd5, 5'd0, 64'h0, 64'h0, 24'h0});
      send_word('{skhct_pkg::REQ_INC, 5'd1, 64'h42, 64'h0, 24'h0, 32'd0}, 1'b1,
                '{skhct_pkg::ST_FULL, 32'hffffffff, 5'd0, 64'h0, 64'h0, 24'h0});
      send_word('{skhct_pkg::REQ_PUT, 5'd1, 64'h42, 64'h0, 24'h0, 32'd0}, 1'b1,
                '{skhct_pkg::ST_FULL, 32'hffffffff, 5'd0, 64'h0, 64'h0, 24'h0});
      write_size(7'd0);
      send_word('{skhct_pkg::REQ_GET, 5'd1, 64'h41, 64'h0, 24'h0, 32'd0}, 1'b1,
                '{skhct_pkg::ST_MISS, 32'hffffffff, 5'd0, 64'h0, 64'h0, 24'h0});
      write_size(7'd127);
      send_word('{skhct_pkg::REQ_INC, 5'd1, 64'h41, 64'h0, 24'h0, 32'd0}, 1'b0, '0);

      // random phases over several sizes; words drawn mostly from a small key pool
      foreach (key_pool[i]) key_pool[i] = make_key(skhct_pkg::REQ_PUT, 19);
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_size(7'd64);
            1: write_size(7'd2);
            2: write_size(7'($urandom_range(3, 16)));
            3: write_size(7'($urandom_range(0, 127)));
            4: write_size(7'd1);
            default: write_size(7'($urandom_range(17, 64)));
         endcase
         for (int i = 0; i < 16; i++) key_pool[$urandom_range(0, 15)] =
            make_key(skhct_pkg::REQ_PUT, $urandom_range(0, 9) < 7 ? 4 : 31);
         n = (phase == 0 || phase == 5) ? 120 : 65;
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 8) begin
               r = key_pool[$urandom_range(0, 15)];
               r.value = $urandom_range(0, 3) == 0 ? {1'b1, 31'($urandom)}
                                                   : 32'($urandom_range(0, 1000));
            end else r = make_key(skhct_pkg::REQ_PUT, 31);
            case ($urandom_range(0, 19))
               0, 1, 2, 3, 4, 5: r.op = skhct_pkg::REQ_PUT;
               6, 7, 8, 9: r.op = skhct_pkg::REQ_GET;
               10, 11, 12, 13, 14: r.op = skhct_pkg::REQ_INC;
               15, 16: r.op = skhct_pkg::REQ_SUM;
               17, 18: r.op = skhct_pkg::REQ_MAX;
               default: r.op = 3'($urandom_range(5, 7));
            endcase
            send_word(r, 1'b0, '0);
         end
      end

      drain();
      if (mismatches == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
`default_nettype wire

[files.f]
sv/skhct_pkg.sv
sv/skhct_datapath.sv
sv/skhct_ctrl.sv
sv/string_key_hash_counter_table_top.sv
tb/tb_string_key_hash_counter_table_top.sv
